FILE: rtl/core/fwh_pkg.sv
// ----------------------------------------------------------------------------
// FIFO with waiter handoff: shared definitions
// Request codes, status codes, default sizes and the response payload type.
// ----------------------------------------------------------------------------
package fwh_pkg;

   localparam int unsigned QUEUE_DEPTH_DEF     = 16;
   localparam int unsigned WAITER_DEPTH_DEF    = 16;
   localparam int unsigned WORD_WIDTH_DEF      = 32;
   localparam int unsigned REQUESTER_COUNT_DEF = 16;

   localparam int unsigned ID_W    = 4;
   localparam int unsigned WORD_W  = 32;
   localparam int unsigned COUNT_W = 32;

   typedef enum logic {
      CMD_ENQUEUE = 1'b0,
      CMD_DEQUEUE = 1'b1
   } cmd_type;

   typedef enum logic {
      STATUS_DELIVERED = 1'b0,
      STATUS_DROPPED   = 1'b1
   } status_type;

   typedef struct packed {
      logic [ID_W-1:0]    dest_requester;
      logic [WORD_W-1:0]  out_word;
      status_type         status;
      logic [COUNT_W-1:0] delivered_count;
   } rsp_data_type;

endpackage

FILE: rtl/core/fwh_if.sv
// ----------------------------------------------------------------------------
// FIFO with waiter handoff: channel interfaces
// Valid/ready channels for requests and responses.
// ----------------------------------------------------------------------------
interface fwh_req_if;
   logic                      valid;
   logic                      ready;
   logic                      cmd;
   logic [fwh_pkg::WORD_W-1:0] item_word;
   logic [fwh_pkg::ID_W-1:0]   requester_id;

   modport source (output valid, output cmd, output item_word, output requester_id,
                   input ready);
   modport sink   (input valid, input cmd, input item_word, input requester_id,
                   output ready);
endinterface

interface fwh_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [fwh_pkg::ID_W-1:0]    dest_requester;
   logic [fwh_pkg::WORD_W-1:0]  out_word;
   logic                        status;
   logic [fwh_pkg::COUNT_W-1:0] delivered_count;

   modport source (output valid, output dest_requester, output out_word, output status,
                   output delivered_count, input ready);
   modport sink   (input valid, input dest_requester, input out_word, input status,
                   input delivered_count, output ready);
endinterface

FILE: rtl/core/fifo_with_waiter_handoff_top.sv
// A response is held in the pending-response register of fwh_ctrl and then in the response register of fwh_out.
// Throughput: one request per cycle while the response path is not stalled; each request
// pushes or pops at most one of the word and waiter FIFOs, with registered read data.
// Reset clears pointers, counts, the delivery total and the response valids.
// The storage arrays are not cleared; entries are read only after a write.
// ----------------------------------------------------------------------------
// FIFO with waiter handoff: top level
// Enqueue and dequeue requests in, deliveries and drop notices out.
// ----------------------------------------------------------------------------
module fifo_with_waiter_handoff_top #(
   parameter int unsigned QUEUE_DEPTH     = fwh_pkg::QUEUE_DEPTH_DEF,
   parameter int unsigned WAITER_DEPTH    = fwh_pkg::WAITER_DEPTH_DEF,
   parameter int unsigned WORD_WIDTH      = fwh_pkg::WORD_WIDTH_DEF,
   parameter int unsigned REQUESTER_COUNT = fwh_pkg::REQUESTER_COUNT_DEF
) (
   input logic       clock,
   input logic       reset,
   fwh_req_if.sink   req_bus,
   fwh_rsp_if.source rsp_bus
);

   logic                  s1_valid;
   logic                  out_ready;
   fwh_pkg::rsp_data_type s1_data;

   fwh_ctrl #(
      .QUEUE_DEPTH     (QUEUE_DEPTH),
      .WAITER_DEPTH    (WAITER_DEPTH),
      .WORD_WIDTH      (WORD_WIDTH),
      .REQUESTER_COUNT (REQUESTER_COUNT)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .out_ready (out_ready),
      .s1_valid  (s1_valid),
      .s1_data   (s1_data)
   );

   fwh_out u_out (
      .clock     (clock),
      .reset     (reset),
      .s1_valid  (s1_valid),
      .s1_data   (s1_data),
      .out_ready (out_ready),
      .rsp_bus   (rsp_bus)
   );

endmodule

FILE: rtl/core/fwh_ram.sv
// ----------------------------------------------------------------------------
// FIFO with waiter handoff: storage array
// One write port and one read port with registered, enabled read data.
// ----------------------------------------------------------------------------
module fwh_ram #(
   parameter int unsigned DEPTH = fwh_pkg::QUEUE_DEPTH_DEF,
   parameter int unsigned WIDTH = fwh_pkg::WORD_WIDTH_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/fwh_ctrl.sv
// ----------------------------------------------------------------------------
// FIFO with waiter handoff: request control
// Decides each request against the word and waiter FIFOs, updates pointers,
// counts and the delivery total, and holds the pending response.
// ----------------------------------------------------------------------------
module fwh_ctrl #(
   parameter int unsigned QUEUE_DEPTH     = fwh_pkg::QUEUE_DEPTH_DEF,
   parameter int unsigned WAITER_DEPTH    = fwh_pkg::WAITER_DEPTH_DEF,
   parameter int unsigned WORD_WIDTH      = fwh_pkg::WORD_WIDTH_DEF,
   parameter int unsigned REQUESTER_COUNT = fwh_pkg::REQUESTER_COUNT_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   fwh_req_if.sink               req_bus,
   input  logic                  out_ready,
   output logic                  s1_valid,
   output fwh_pkg::rsp_data_type s1_data
);

   localparam int unsigned QAW = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCW = $clog2(QUEUE_DEPTH + 1);
   localparam int unsigned WAW = $clog2(WAITER_DEPTH);
   localparam int unsigned WCW = $clog2(WAITER_DEPTH + 1);
   localparam int unsigned IDW = $clog2(REQUESTER_COUNT);

   logic [QAW-1:0] word_head_ff, word_head_in, word_tail_ff, word_tail_in;
   logic [QCW-1:0] word_count_ff, word_count_in;
   logic [WAW-1:0] waiter_head_ff, waiter_head_in, waiter_tail_ff, waiter_tail_in;
   logic [WCW-1:0] waiter_count_ff, waiter_count_in;
   logic [fwh_pkg::COUNT_W-1:0] total_ff, total_in;

   logic                         s1_valid_ff, s1_valid_in;
   logic                         s1_word_mem_ff;
   logic                         s1_id_mem_ff;
   logic [fwh_pkg::ID_W-1:0]     s1_dest_ff;
   logic [fwh_pkg::WORD_W-1:0]   s1_word_ff;
   fwh_pkg::status_type          s1_status_ff;
   logic [fwh_pkg::COUNT_W-1:0]  s1_count_ff;

   logic accept, is_deq, words_empty, words_full, waiters_empty, waiters_full;
   logic enq_hand, enq_store, enq_drop, deq_pop, deq_wait, deq_drop, has_result;
   logic [WORD_WIDTH-1:0] word_rdata;
   logic [IDW-1:0]        waiter_rdata;

   assign req_bus.ready = !s1_valid_ff || out_ready;
   assign accept        = req_bus.valid && req_bus.ready;
   assign is_deq        = (fwh_pkg::cmd_type'(req_bus.cmd) == fwh_pkg::CMD_DEQUEUE);

   assign words_empty   = (word_count_ff == '0);
   assign words_full    = (word_count_ff == QCW'(QUEUE_DEPTH));
   assign waiters_empty = (waiter_count_ff == '0);
   assign waiters_full  = (waiter_count_ff == WCW'(WAITER_DEPTH));

   assign enq_hand   = !is_deq && !waiters_empty;
   assign enq_store  = !is_deq && waiters_empty && !words_full;
   assign enq_drop   = !is_deq && waiters_empty && words_full;
   assign deq_pop    = is_deq && !words_empty;
   assign deq_wait   = is_deq && words_empty && !waiters_full;
   assign deq_drop   = is_deq && words_empty && waiters_full;
   assign has_result = enq_hand || enq_drop || deq_pop || deq_drop;

   fwh_ram #(.DEPTH(QUEUE_DEPTH), .WIDTH(WORD_WIDTH)) u_word_ram (
      .clock   (clock),
      .wr_en   (accept && enq_store),
      .wr_addr (word_tail_ff),
      .wr_data (WORD_WIDTH'(req_bus.item_word)),
      .rd_en   (accept && deq_pop),
      .rd_addr (word_head_ff),
      .rd_data (word_rdata)
   );

   fwh_ram #(.DEPTH(WAITER_DEPTH), .WIDTH(IDW)) u_waiter_ram (
      .clock   (clock),
      .wr_en   (accept && deq_wait),
      .wr_addr (waiter_tail_ff),
      .wr_data (IDW'(req_bus.requester_id)),
      .rd_en   (accept && enq_hand),
      .rd_addr (waiter_head_ff),
      .rd_data (waiter_rdata)
   );

   always_comb begin
      word_head_in    = word_head_ff;
      word_tail_in    = word_tail_ff;
      word_count_in   = word_count_ff;
      waiter_head_in  = waiter_head_ff;
      waiter_tail_in  = waiter_tail_ff;
      waiter_count_in = waiter_count_ff;
      total_in        = total_ff;
      if (accept) begin
         if (enq_hand) begin
            waiter_head_in  = (waiter_head_ff == WAW'(WAITER_DEPTH - 1)) ? '0
                              : waiter_head_ff + 1'b1;
            waiter_count_in = waiter_count_ff - 1'b1;
         end
         if (enq_store) begin
            word_tail_in  = (word_tail_ff == QAW'(QUEUE_DEPTH - 1)) ? '0
                            : word_tail_ff + 1'b1;
            word_count_in = word_count_ff + 1'b1;
         end
         if (deq_pop) begin
            word_head_in  = (word_head_ff == QAW'(QUEUE_DEPTH - 1)) ? '0
                            : word_head_ff + 1'b1;
            word_count_in = word_count_ff - 1'b1;
         end
         if (deq_wait) begin
            waiter_tail_in  = (waiter_tail_ff == WAW'(WAITER_DEPTH - 1)) ? '0
                              : waiter_tail_ff + 1'b1;
            waiter_count_in = waiter_count_ff + 1'b1;
         end
         if (enq_hand || deq_pop) begin
            total_in = total_ff + 1'b1;
         end
      end
   end

   always_comb begin
      if (accept) begin
         s1_valid_in = has_result;
      end else if (out_ready) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_head_ff    <= '0;
         word_tail_ff    <= '0;
         word_count_ff   <= '0;
         waiter_head_ff  <= '0;
         waiter_tail_ff  <= '0;
         waiter_count_ff <= '0;
         total_ff        <= '0;
         s1_valid_ff     <= 1'b0;
      end else begin
         word_head_ff    <= word_head_in;
         word_tail_ff    <= word_tail_in;
         word_count_ff   <= word_count_in;
         waiter_head_ff  <= waiter_head_in;
         waiter_tail_ff  <= waiter_tail_in;
         waiter_count_ff <= waiter_count_in;
         total_ff        <= total_in;
         s1_valid_ff     <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_word_mem_ff <= deq_pop;
         s1_id_mem_ff   <= enq_hand;
         s1_dest_ff     <= is_deq ? req_bus.requester_id : '0;
         s1_word_ff     <= enq_hand ? fwh_pkg::WORD_W'(WORD_WIDTH'(req_bus.item_word)) : '0;
         s1_status_ff   <= (enq_drop || deq_drop) ? fwh_pkg::STATUS_DROPPED
                           : fwh_pkg::STATUS_DELIVERED;
         s1_count_ff    <= total_in;
      end
   end

   assign s1_valid                = s1_valid_ff;
   assign s1_data.dest_requester  = s1_id_mem_ff ? fwh_pkg::ID_W'(waiter_rdata) : s1_dest_ff;
   assign s1_data.out_word        = s1_word_mem_ff ? fwh_pkg::WORD_W'(word_rdata) : s1_word_ff;
   assign s1_data.status          = s1_status_ff;
   assign s1_data.delivered_count = s1_count_ff;

   // Words and waiters are never queued at the same time.
   assert property (@(posedge clock) disable iff (reset)
      !(word_count_ff != '0 && waiter_count_ff != '0))
      else $error("word and waiter FIFOs both occupied");

   assert property (@(posedge clock) disable iff (reset)
      word_count_ff <= QCW'(QUEUE_DEPTH) && waiter_count_ff <= WCW'(WAITER_DEPTH))
      else $error("FIFO count beyond depth");

   assert property (@(posedge clock) disable iff (reset)
      accept && (enq_hand || deq_pop) |=> total_ff == $past(total_ff) + 1'b1)
      else $error("delivery total did not advance on a delivery");

   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !out_ready |=> s1_valid_ff && $stable(s1_count_ff))
      else $error("pending response lost while output stalled");

endmodule

FILE: rtl/core/fwh_out.sv
// ----------------------------------------------------------------------------
// FIFO with waiter handoff: response register
// Holds one response on the output channel until it is taken.
// ----------------------------------------------------------------------------
module fwh_out (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  s1_valid,
   input  fwh_pkg::rsp_data_type s1_data,
   output logic                  out_ready,
   fwh_rsp_if.source             rsp_bus
);

   logic                  rsp_valid_ff, rsp_valid_in;
   fwh_pkg::rsp_data_type rsp_data_ff;

   assign out_ready    = !rsp_valid_ff || rsp_bus.ready;
   assign rsp_valid_in = out_ready ? s1_valid : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && s1_valid) begin
         rsp_data_ff <= s1_data;
      end
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.dest_requester  = rsp_data_ff.dest_requester;
   assign rsp_bus.out_word        = rsp_data_ff.out_word;
   assign rsp_bus.status          = rsp_data_ff.status;
   assign rsp_bus.delivered_count = rsp_data_ff.delivered_count;

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FIFO with waiter handoff: testbench
// Drives enqueue and dequeue requests through random valid/ready gaps and
// checks every response against a cycle-free prediction of both FIFOs.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int unsigned WORD_SLOTS   = fwh_pkg::QUEUE_DEPTH_DEF;
   localparam int unsigned WAITER_SLOTS = fwh_pkg::WAITER_DEPTH_DEF;
   localparam int LATENCY = 2;

   typedef struct packed {
      fwh_pkg::cmd_type               cmd;
      logic [fwh_pkg::WORD_W-1:0]     word;
      logic [fwh_pkg::ID_W-1:0]       id;
   } request_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   fwh_req_if req_ch();
   fwh_rsp_if rsp_ch();

   fifo_with_waiter_handoff_top uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_ch),
      .rsp_bus (rsp_ch)
   );

   request_type                 pending_requests[$];
   fwh_pkg::rsp_data_type       expected_responses[$];
   logic [fwh_pkg::WORD_W-1:0]  stored_words[$];
   logic [fwh_pkg::ID_W-1:0]    waiting_ids[$];
   logic [fwh_pkg::COUNT_W-1:0] delivery_total = '0;
   request_type                 next_req;
   fwh_pkg::rsp_data_type       want;
   int                          send_idle_pct = 0;
   int                          recv_idle_pct = 0;
   int                          mismatch_count = 0;

   always #4 clock = ~clock;

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      $display("%0t: mismatch: %s", $time, msg);
   endtask

   function automatic void serve_request(input request_type r);
      fwh_pkg::rsp_data_type rsp;
      rsp = '0;
      rsp.status = fwh_pkg::STATUS_DELIVERED;
      if (r.cmd == fwh_pkg::CMD_ENQUEUE) begin
         if (waiting_ids.size() > 0) begin
            delivery_total++;
            rsp.dest_requester  = waiting_ids.pop_front();
            rsp.out_word        = r.word;
            rsp.delivered_count = delivery_total;
            expected_responses.push_back(rsp);
         end else if (stored_words.size() < WORD_SLOTS) begin
            stored_words.push_back(r.word);
         end else begin
            rsp.status          = fwh_pkg::STATUS_DROPPED;
            rsp.delivered_count = delivery_total;
            expected_responses.push_back(rsp);
         end
      end else begin
         if (stored_words.size() > 0) begin
            delivery_total++;
            rsp.dest_requester  = r.id;
            rsp.out_word        = stored_words.pop_front();
            rsp.delivered_count = delivery_total;
            expected_responses.push_back(rsp);
         end else if (waiting_ids.size() < WAITER_SLOTS) begin
            waiting_ids.push_back(r.id);
         end else begin
            rsp.dest_requester  = r.id;
            rsp.status          = fwh_pkg::STATUS_DROPPED;
            rsp.delivered_count = delivery_total;
            expected_responses.push_back(rsp);
         end
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            serve_request(request_type'{fwh_pkg::cmd_type'(req_ch.cmd), req_ch.item_word,
                                        req_ch.requester_id});
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               next_req = pending_requests.pop_front();
               req_ch.valid        <= 1'b1;
               req_ch.cmd          <= next_req.cmd;
               req_ch.item_word    <= next_req.word;
               req_ch.requester_id <= next_req.id;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_responses.size() == 0) begin
               report_mismatch($sformatf("response to requester %0d with nothing pending",
                                         rsp_ch.dest_requester));
            end else begin
               want = expected_responses.pop_front();
               if (rsp_ch.dest_requester !== want.dest_requester)
                  report_mismatch($sformatf("dest_requester %0d, expected %0d",
                                            rsp_ch.dest_requester, want.dest_requester));
               if (rsp_ch.out_word !== want.out_word)
                  report_mismatch($sformatf("out_word %h, expected %h",
                                            rsp_ch.out_word, want.out_word));
               if (rsp_ch.status !== want.status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_ch.status, want.status));
               if (rsp_ch.delivered_count !== want.delivered_count)
                  report_mismatch($sformatf("delivered_count %0d, expected %0d",
                                            rsp_ch.delivered_count, want.delivered_count));
            end
         end
      end
   end

   task automatic push_request(input fwh_pkg::cmd_type cmd,
                               input logic [fwh_pkg::WORD_W-1:0] word,
                               input logic [fwh_pkg::ID_W-1:0] id);
      pending_requests.push_back(request_type'{cmd, word, id});
   endtask

   // Bursts, mostly of one kind, walk both stores between empty and full.
   task automatic add_random_requests(input int target);
      int               n;
      int               kind;
      int               len;
      fwh_pkg::cmd_type cmd;
      n = 0;
      while (n < target) begin
         kind = $urandom_range(9);
         len  = $urandom_range(24, 1);
         repeat (len) begin
            if (kind < 4)
               cmd = fwh_pkg::CMD_ENQUEUE;
            else if (kind < 8)
               cmd = fwh_pkg::CMD_DEQUEUE;
            else
               cmd = fwh_pkg::cmd_type'($urandom_range(1));
            push_request(cmd, $urandom, fwh_pkg::ID_W'($urandom_range(15)));
            n++;
         end
      end
   endtask

   task automatic drain_and_settle();
      while (pending_requests.size() != 0 || req_ch.valid)
         @(posedge clock);
      while (expected_responses.size() != 0)
         @(posedge clock);
      repeat (LATENCY + 2) @(posedge clock);
   endtask

   initial begin
      req_ch.valid        = 1'b0;
      req_ch.cmd          = 1'b0;
      req_ch.item_word    = '0;
      req_ch.requester_id = '0;
      rsp_ch.ready        = 1'b0;
      send_idle_pct = 22;
      recv_idle_pct = 70;

      push_request(fwh_pkg::CMD_ENQUEUE, 32'h0000_0000, 4'd0);
      push_request(fwh_pkg::CMD_ENQUEUE, 32'hFFFF_FFFF, 4'd15);
      push_request(fwh_pkg::CMD_DEQUEUE, 32'hFFFF_FFFF, 4'd0);
      push_request(fwh_pkg::CMD_DEQUEUE, 32'h0000_0000, 4'd15);
      push_request(fwh_pkg::CMD_DEQUEUE, $urandom, 4'd5);
      push_request(fwh_pkg::CMD_DEQUEUE, $urandom, 4'd10);
      push_request(fwh_pkg::CMD_ENQUEUE, 32'hA5A5_A5A5, fwh_pkg::ID_W'($urandom_range(15)));
      push_request(fwh_pkg::CMD_ENQUEUE, 32'h5A5A_5A5A, fwh_pkg::ID_W'($urandom_range(15)));
      repeat (WORD_SLOTS)
         push_request(fwh_pkg::CMD_ENQUEUE, $urandom, fwh_pkg::ID_W'($urandom_range(15)));
      push_request(fwh_pkg::CMD_ENQUEUE, 32'hDEAD_BEEF, 4'd7);

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      add_random_requests(525);
      drain_and_settle();

      send_idle_pct = 70;
      recv_idle_pct = 22;
      add_random_requests(550);
      drain_and_settle();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      add_random_requests(550);
      drain_and_settle();

      if (expected_responses.size() != 0)
         report_mismatch($sformatf("%0d responses never arrived", expected_responses.size()));
      if (mismatch_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

FILE: fifo_with_waiter_handoff_top.f
rtl/core/fwh_pkg.sv
rtl/core/fwh_if.sv
rtl/core/fwh_ram.sv
rtl/core/fwh_ctrl.sv
rtl/core/fwh_out.sv
rtl/core/fifo_with_waiter_handoff_top.sv
dv/tb_top.sv
